>>> src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with search and delete.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int OUT_W    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_DELETE    = 3'd4,
        OP_SEARCH    = 3'd5,
        OP_CLEAR     = 3'd6
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cmp_en;
    } t_cell_ctrl;

endpackage

>>> src/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One list slot: holds a value, compares it against a key and takes a new
// value from the load bus or from either neighbor.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic                                i_clk,
    input  bdq_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [bdq_pkg::VAL_W-1:0]    i_key,
    input  logic signed [bdq_pkg::VAL_W-1:0]    i_load_value,
    input  logic signed [bdq_pkg::VAL_W-1:0]    i_left,
    input  logic signed [bdq_pkg::VAL_W-1:0]    i_right,
    output logic signed [bdq_pkg::VAL_W-1:0]    o_value,
    output logic                                o_match
);
    import bdq_pkg::*;

    logic signed [VAL_W-1:0] r_value;
    logic                    r_match;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_LOAD:       r_value <= i_load_value;
            CELL_FROM_LEFT:  r_value <= i_left;
            CELL_FROM_RIGHT: r_value <= i_right;
            default:         r_value <= r_value;
        endcase
        if (i_ctrl.cmp_en) begin
            r_match <= (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

>>> src/bounded_deque_with_search_delete.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search_delete
// Ordered list of up to CAPACITY signed values held in a row of cells, with
// push and pop at both ends, delete of the first equal entry, search, clear.
//
//   Channel  Dir  Handshake                      Payload
//   s_axis   in   s_axis_tvalid / s_axis_tready  tuser: operation, tdata: value
//   m_axis   out  m_axis_tvalid / m_axis_tready  tdata: status, position, count
//
// Each item is handled in an accept cycle, which registers a compare result in
// every cell, and then the execute state, which picks the first match and shifts the row.
// The next item can be accepted in the cycle after the previous one completes.
// A result waiting in the output register stalls completion of the next item.
// Reset is synchronous and active low; it empties the list.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_delete (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] item_value
    input  logic signed [bdq_pkg::VAL_W-1:0] s_axis_tdata,
    // [2:0] operation
    input  logic [bdq_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [5:2] match_position, [10:6] entry_count, [15:11] zero
    output logic [bdq_pkg::OUT_W-1:0]     m_axis_tdata
);
    import bdq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    t_op                     r_op;
    logic signed [VAL_W-1:0] r_key;
    logic [CNT_W-1:0]        r_count;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    logic [CNT_W-1:0]        n_count;
    t_status                 n_status;
    logic [IDX_W-1:0]        n_pos;

    logic                    w_accept;
    logic                    w_done;
    logic                    w_found;
    logic [IDX_W-1:0]        w_first;
    logic [CAPACITY-1:0]     w_match;
    logic [CAPACITY-1:0]     w_hit;
    logic                    w_full;
    logic                    w_empty;
    t_cell_ctrl              w_ctrl [CAPACITY];
    logic signed [VAL_W-1:0] w_value [CAPACITY];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_done        = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);
    assign w_full        = (r_count >= CNT_W'(CAPACITY));
    assign w_empty       = (r_count == '0);

    always_comb begin
        w_first = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            w_hit[i] = w_match[i] && (CNT_W'(i) < r_count);
            if (w_hit[i]) begin
                w_first = IDX_W'(i);
            end
        end
        w_found = |w_hit;
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_pos    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctrl[i].op     = CELL_HOLD;
            w_ctrl[i].cmp_en = w_accept;
        end
        case (r_op)
            OP_PUSH_HEAD: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        w_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
                    end
                end
            end
            OP_PUSH_TAIL: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CNT_W'(i) == r_count) begin
                            w_ctrl[i].op = CELL_LOAD;
                        end
                    end
                end
            end
            OP_POP_HEAD: begin
                if (w_empty) begin
                    n_status = ST_NONE;
                end else begin
                    n_count = r_count - 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        w_ctrl[i].op = CELL_FROM_RIGHT;
                    end
                end
            end
            OP_POP_TAIL: begin
                if (w_empty) begin
                    n_status = ST_NONE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_DELETE: begin
                if (!w_found) begin
                    n_status = ST_NONE;
                end else begin
                    n_count = r_count - 1'b1;
                    n_pos   = w_first;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (IDX_W'(i) >= w_first) begin
                            w_ctrl[i].op = CELL_FROM_RIGHT;
                        end
                    end
                end
            end
            OP_SEARCH: begin
                if (!w_found) begin
                    n_status = ST_NONE;
                end else begin
                    n_pos = w_first;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!w_done) begin
            for (int i = 0; i < CAPACITY; i++) begin
                w_ctrl[i].op = CELL_HOLD;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bdq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl[g]),
            .i_key        (s_axis_tdata),
            .i_load_value (r_key),
            .i_left       ((g == 0) ? r_key : w_value[(g == 0) ? 0 : g - 1]),
            .i_right      ((g == CAPACITY - 1) ? w_value[g]
                                               : w_value[(g == CAPACITY - 1) ? g : g + 1]),
            .o_value      (w_value[g]),
            .o_match      (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !w_done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= t_op'(s_axis_tuser);
                        r_key   <= s_axis_tdata;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_done) begin
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_out_data  <= {(OUT_W - STAT_W - POS_W - COUNT_W)'(0),
                                        COUNT_W'(n_count), POS_W'(n_pos), n_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[STAT_W-1:0] == ST_FULL)
        |-> (m_axis_tdata[STAT_W+POS_W+COUNT_W-1:STAT_W+POS_W] == COUNT_W'(CAPACITY)))
        else $error("push refused while list not full");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && (r_op != OP_CLEAR)
        |=> ((CNT_W+1)'(r_count) <= (CNT_W+1)'($past(r_count)) + 1'b1)
            && ((CNT_W+1)'(r_count) + 1'b1 >= (CNT_W+1)'($past(r_count))))
        else $error("entry count moved by more than one");

    a_no_mid_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && !w_done |=> $stable(r_count))
        else $error("entry count changed while result was stalled");

endmodule

>>> tb/deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches both stream channels of the bounded deque. Each accepted input item
// is applied to a local copy of the list to work out its result, which waits
// in order until the block delivers one. Every delivered result is compared
// field by field with the oldest waiting one.
// ----------------------------------------------------------------------------
module deque_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    // [31:0] item_value
    input  logic [bdq_pkg::VAL_W-1:0]    s_axis_tdata,
    // [2:0] operation
    input  logic [bdq_pkg::OP_W-1:0]     s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [1:0] status, [5:2] match_position, [10:6] entry_count, [15:11] zero
    input  logic [bdq_pkg::OUT_W-1:0]    m_axis_tdata,
    output int                           o_mismatch_count,
    output int                           o_pending
);
    import bdq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_status             status;
        logic [POS_W-1:0]    pos;
        logic [COUNT_W-1:0]  count;
    } t_deque_result;

    logic [VAL_W-1:0] list_values [CAPACITY];
    int               list_len;
    t_deque_result    result_q [$];

    function automatic void remove_entry(input int at);
        int i;
        for (i = at; i < list_len - 1; i++) begin
            list_values[i] = list_values[i + 1];
        end
        list_len--;
    endfunction

    function automatic t_deque_result apply_op(input logic [OP_W-1:0] op,
                                               input logic [VAL_W-1:0] val);
        t_deque_result r;
        int            hit;
        int            i;
        r.status = ST_OK;
        r.pos    = '0;
        hit      = -1;
        for (i = 0; i < list_len; i++) begin
            if (hit < 0 && list_values[i] == val) begin
                hit = i;
            end
        end
        case (op)
            OP_PUSH_HEAD: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > 0; i--) begin
                        list_values[i] = list_values[i - 1];
                    end
                    list_values[0] = val;
                    list_len++;
                end
            end
            OP_PUSH_TAIL: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_values[list_len] = val;
                    list_len++;
                end
            end
            OP_POP_HEAD: begin
                if (list_len == 0) begin
                    r.status = ST_NONE;
                end else begin
                    remove_entry(0);
                end
            end
            OP_POP_TAIL: begin
                if (list_len == 0) begin
                    r.status = ST_NONE;
                end else begin
                    list_len--;
                end
            end
            OP_DELETE: begin
                if (hit >= 0) begin
                    r.pos = hit[POS_W-1:0];
                    remove_entry(hit);
                end else begin
                    r.status = ST_NONE;
                end
            end
            OP_SEARCH: begin
                if (hit >= 0) begin
                    r.pos = hit[POS_W-1:0];
                end else begin
                    r.status = ST_NONE;
                end
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            list_len = 0;
            result_q.delete();
            o_pending <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    if (o_mismatch_count < REPORT_LIMIT) begin
                        $display("Unexpected result %h with no item outstanding",
                                 m_axis_tdata);
                    end
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    want = result_q.pop_front();
                    if (m_axis_tdata[1:0] != want.status ||
                        m_axis_tdata[5:2] != want.pos ||
                        m_axis_tdata[10:6] != want.count ||
                        m_axis_tdata[15:11] != '0) begin
                        if (o_mismatch_count < REPORT_LIMIT) begin
                            $display({"Result mismatch: expected status %0d pos %0d ",
                                      "count %0d, got status %0d pos %0d count %0d ",
                                      "pad %0h"},
                                     want.status, want.pos, want.count,
                                     m_axis_tdata[1:0], m_axis_tdata[5:2],
                                     m_axis_tdata[10:6], m_axis_tdata[15:11]);
                        end
                        o_mismatch_count <= o_mismatch_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                result_q.push_back(apply_op(s_axis_tuser, s_axis_tdata));
            end
            o_pending <= result_q.size();
        end
    end

endmodule

>>> tb/bounded_deque_with_search_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_delete_tb
// Drives the bounded deque with a short directed sequence and then with
// random episodes that fill the list past full, drain it past empty, and mix
// all operations over a small pool of repeating values. The sender works in
// bursts and the receiver stalls on its own pattern. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_delete_tb;
    import bdq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int ITEM_TARGET  = 900;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 16;
    localparam int POOL_SIZE    = 8;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [VAL_W-1:0]   s_axis_tdata  = '0;
    logic [OP_W-1:0]    s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;

    int                 mismatch_count;
    int                 pending;
    int                 stall_cycles  = 0;
    int                 items_sent    = 0;
    int                 burst_left    = 0;
    int                 rx_mode       = 0;
    int                 rx_left       = 0;
    int                 rx_phase      = 0;
    logic [VAL_W-1:0]   value_pool [POOL_SIZE];

    bounded_deque_with_search_delete dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    deque_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((rx_phase % 8) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic refresh_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(0, 4))
                0: value_pool[i] = 32'h8000_0000;
                1: value_pool[i] = 32'h7fff_ffff;
                2: value_pool[i] = $urandom_range(0, 3);
                3: value_pool[i] = 32'hffff_ffff - $urandom_range(0, 2);
                default: value_pool[i] = $urandom;
            endcase
        end
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 4) == 0) begin
            return $urandom;
        end
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 20) return OP_PUSH_HEAD;
        if (w < 40) return OP_PUSH_TAIL;
        if (w < 50) return OP_POP_HEAD;
        if (w < 60) return OP_POP_TAIL;
        if (w < 75) return OP_DELETE;
        if (w < 95) return OP_SEARCH;
        return OP_CLEAR;
    endfunction

    task automatic run_fill();
        int pushes;
        int goal;
        pushes = 0;
        goal   = CAPACITY + $urandom_range(1, 6);
        while (pushes < goal) begin
            if ($urandom_range(0, 4) == 0) begin
                send_item(OP_SEARCH, pick_value());
            end else begin
                send_item($urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL, pick_value());
                pushes++;
            end
        end
    endtask

    task automatic run_drain();
        int pops;
        int goal;
        pops = 0;
        goal = CAPACITY + $urandom_range(1, 6);
        while (pops < goal) begin
            case ($urandom_range(0, 5))
                0: send_item(OP_DELETE, pick_value());
                1: send_item(OP_SEARCH, pick_value());
                2, 3: begin
                    send_item(OP_POP_HEAD, pick_value());
                    pops++;
                end
                default: begin
                    send_item(OP_POP_TAIL, pick_value());
                    pops++;
                end
            endcase
        end
    endtask

    initial begin
        int episode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_POP_HEAD, 32'h0000_0000);
        send_item(OP_POP_TAIL, 32'hffff_ffff);
        send_item(OP_DELETE, 32'h0000_0000);
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_UNUSED, 32'h8000_0000);
        send_item(OP_PUSH_HEAD, 32'h7fff_ffff);
        send_item(OP_PUSH_TAIL, 32'h8000_0000);
        send_item(OP_PUSH_HEAD, 32'h0000_0000);
        send_item(OP_PUSH_TAIL, 32'hffff_ffff);
        send_item(OP_PUSH_TAIL, 32'h0000_0000);
        send_item(OP_SEARCH, 32'h8000_0000);
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_SEARCH, 32'h1234_5678);
        send_item(OP_DELETE, 32'h0000_0000);
        send_item(OP_DELETE, 32'h7fff_fffe);
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_UNUSED, 32'h7fff_ffff);
        send_item(OP_POP_HEAD, 32'h0000_0000);
        send_item(OP_POP_TAIL, 32'h0000_0000);
        send_item(OP_CLEAR, 32'hffff_ffff);
        send_item(OP_SEARCH, 32'h7fff_ffff);
        wait_for_results();

        episode = 0;
        while (items_sent < ITEM_TARGET) begin
            refresh_pool();
            case ($urandom_range(0, 5))
                0, 1: run_fill();
                2: run_drain();
                3: begin
                    repeat ($urandom_range(4, 12)) begin
                        send_item(OP_W'($urandom_range(0, 6)), $urandom);
                    end
                end
                default: begin
                    repeat ($urandom_range(10, 40)) send_item(pick_op(), pick_value());
                end
            endcase
            episode++;
            if (episode % 5 == 0) begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
